### hw/rtl/ic3k_pkg.sv
// Shared types and constants for the 3x3 image convolution block.
// Holds the kernel coefficient table, register indexes and result layout.
// No dependencies.
package ic3k_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int POS_W  = $clog2(MAX_WIDTH);          // column / row counters
  localparam int DIM_W  = 11;                         // geometry registers
  localparam int SUM_W  = 14;                         // filtered_sum field
  localparam int ACC_W  = 17;                         // internal accumulation
  localparam int COEF_W = 6;

  localparam int LINE_DEPTH = MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int FILL_W     = LINE_AW + 1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(3);
  localparam logic [DIM_W-1:0] COLS_MAX      = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] ROWS_MAX      = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_RESET     = DIM_W'(512);
  localparam logic [2:0]       KSEL_RESET    = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_COLUMNS = 2'd0,
    REG_IMAGE_ROWS    = 2'd1,
    REG_KERNEL_SELECT = 2'd2
  } cfg_reg_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t kernel_t [3][3];

  // Row 0 applies to the oldest line, column 0 to the leftmost pixel.
  localparam kernel_t KERNELS [8] = '{
    '{'{ 6'sd0,  6'sd1,  6'sd0}, '{ 6'sd1, -6'sd4,  6'sd1}, '{ 6'sd0,  6'sd1,  6'sd0}},
    '{'{-6'sd1, -6'sd1, -6'sd1}, '{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd1,  6'sd1,  6'sd1}},
    '{'{-6'sd1,  6'sd0,  6'sd1}, '{-6'sd1,  6'sd0,  6'sd1}, '{-6'sd1,  6'sd0,  6'sd1}},
    '{'{-6'sd1, -6'sd2, -6'sd1}, '{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd1,  6'sd2,  6'sd1}},
    '{'{-6'sd1,  6'sd0,  6'sd1}, '{-6'sd2,  6'sd0,  6'sd2}, '{-6'sd1,  6'sd0,  6'sd1}},
    '{'{-6'sd1, -6'sd1, -6'sd1}, '{-6'sd1,  6'sd17, -6'sd1}, '{-6'sd1, -6'sd1, -6'sd1}},
    '{'{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd0,  6'sd0,  6'sd0}},
    '{'{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd0,  6'sd0,  6'sd0}, '{ 6'sd0,  6'sd0,  6'sd0}}
  };

  typedef struct packed {
    logic              last;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [SUM_W-1:0]  sum;
  } result_t;

endpackage

### hw/rtl/image_conv3x3_kernels.sv
// Streaming 3x3 convolution over 8-bit grey pixels with six fixed kernels.
// Depends on ic3k_pkg (geometry limits, kernel table, result layout).

// Usage: pixels enter in raster order, one beat per clock, and the block keeps
// taking one pixel every cycle for as long as results are drained. A pixel
// that completes a full 3x3 window (row and column both at least 2) yields one
// result beat after the pipeline stages and the result queue: the raw signed kernel sum
// (wrapped to 14 bits), the row and column of the window centre, and tlast on
// the final result of the frame. Border pixels give no result. The two
// previous image lines sit in one 1024 x 16-bit synchronous memory, read at
// the incoming column on acceptance and rewritten in the next cycle; a fill
// count stands in for clearing it, so no clearing pass follows reset. An
// eight-entry result queue decouples the output, and in_tready drops only when
// the queue plus the results still in flight would fill it. Writing the
// column or row count restarts the frame; write registers only while idle.
module image_conv3x3_kernels (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ic3k_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] pixel
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ic3k_pkg::OUT_DATA_W-1:0]   out_tdata,  // [13:0] filtered_sum,
                                                        // [23:14] centre_row,
                                                        // [33:24] centre_column,
                                                        // [39:34] zero
  output logic                              out_tlast,  // frame_end
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [ic3k_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ic3k_pkg::DIM_W-1:0]        cfg_data
);

  import ic3k_pkg::*;

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0] img_cols_r;
  logic [DIM_W-1:0] img_rows_r;
  logic [2:0]       ksel_r;
  logic             geom_wr;

  assign geom_wr = cfg_wr_en &&
                   (cfg_index == REG_IMAGE_COLUMNS || cfg_index == REG_IMAGE_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cols_r <= DIM_RESET;
      img_rows_r <= DIM_RESET;
      ksel_r     <= KSEL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_COLUMNS: img_cols_r <= cfg_data;
        REG_IMAGE_ROWS:    img_rows_r <= cfg_data;
        REG_KERNEL_SELECT: ksel_r     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry into the range the line store supports.
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;

  always_comb begin
    if (img_cols_r < DIM_MIN)       cols_eff = DIM_MIN;
    else if (img_cols_r > COLS_MAX) cols_eff = COLS_MAX;
    else                            cols_eff = img_cols_r;
    if (img_rows_r < DIM_MIN)       rows_eff = DIM_MIN;
    else if (img_rows_r > ROWS_MAX) rows_eff = ROWS_MAX;
    else                            rows_eff = img_rows_r;
  end

  // ------------------------------------------------------------ handshake
  logic               in_acc;
  logic               fifo_push;
  logic               fifo_pop;
  logic [FIFO_CW-1:0] fifo_cnt_r;
  logic [FIFO_CW-1:0] pending;

  logic s1_valid_r, s1_emit_r;
  logic s2_valid_r, s3_valid_r;

  // Reserve a queue slot for every result still in the pipe.
  assign pending   = fifo_cnt_r + FIFO_CW'(s1_valid_r && s1_emit_r)
                   + FIFO_CW'(s2_valid_r) + FIFO_CW'(s3_valid_r);
  assign in_tready = (pending < FIFO_CW'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  // ----------------------------------------------------- position counters
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             acc_emit, acc_last;

  always_comb begin
    col_inc  = DIM_W'(col_r) + DIM_W'(1);
    row_inc  = DIM_W'(row_r) + DIM_W'(1);
    acc_emit = (row_r >= POS_W'(2)) && (col_r >= POS_W'(2));
    acc_last = (row_inc == rows_eff) && (col_inc == cols_eff);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (col_inc >= cols_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= rows_eff) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_nxt = col_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geom_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------------------------ line store
  // Entry bits [7:0] hold the older line, [15:8] the newer one. Columns are
  // always visited upwards from zero, so the written entries form a prefix
  // and a fill count tells which reads must return the reset value.
  logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
  logic [2*PIX_W-1:0] line_rd_r;
  logic [FILL_W-1:0]  fill_r;

  logic [PIX_W-1:0]   s1_px_r;
  logic [LINE_AW-1:0] s1_col_r;
  logic [POS_W-1:0]   s1_ccol_r, s1_crow_r;
  logic               s1_last_r, s1_hit_r;
  logic [PIX_W-1:0]   top, mid;

  always_ff @(posedge clk) begin
    if (in_acc) line_rd_r <= line_mem[col_r[LINE_AW-1:0]];
    if (s1_valid_r) line_mem[s1_col_r] <= {s1_px_r, mid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc && (FILL_W'(col_r) == fill_r)) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // stage 1: pixel and position wait for the line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_emit_r  <= acc_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_tdata[PIX_W-1:0];
      s1_col_r  <= col_r[LINE_AW-1:0];
      s1_ccol_r <= col_r - POS_W'(1);
      s1_crow_r <= row_r - POS_W'(1);
      s1_last_r <= acc_last;
      s1_hit_r  <= (FILL_W'(col_r) < fill_r);
    end
  end

  assign top = s1_hit_r ? line_rd_r[PIX_W-1:0]       : '0;
  assign mid = s1_hit_r ? line_rd_r[2*PIX_W-1:PIX_W] : '0;

  // ---------------------------------------------------------------- window
  logic [PIX_W-1:0] win_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++)
        for (int l = 0; l < 3; l++)
          win_r[k][l] <= '0;
    end else if (s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top;
      win_r[1][2] <= mid;
      win_r[2][2] <= s1_px_r;
    end
  end

  // stage 2: window complete, form one partial sum per kernel row
  logic [POS_W-1:0] s2_ccol_r, s2_crow_r, s3_ccol_r, s3_crow_r;
  logic             s2_last_r, s3_last_r;
  logic signed [ACC_W-1:0] row_sum [3];
  logic signed [ACC_W-1:0] s3_rsum_r [3];
  logic signed [ACC_W-1:0] total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ccol_r <= s1_ccol_r;
    s2_crow_r <= s1_crow_r;
    s2_last_r <= s1_last_r;
    s3_ccol_r <= s2_ccol_r;
    s3_crow_r <= s2_crow_r;
    s3_last_r <= s2_last_r;
    for (int k = 0; k < 3; k++) s3_rsum_r[k] <= row_sum[k];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = '0;
      for (int l = 0; l < 3; l++)
        row_sum[k] = row_sum[k]
                   + ACC_W'($signed({1'b0, win_r[k][l]})) * ACC_W'(KERNELS[ksel_r][k][l]);
    end
  end

  // stage 3: add the row sums and hand the result to the queue
  assign total = s3_rsum_r[0] + s3_rsum_r[1] + s3_rsum_r[2];

  // ---------------------------------------------------------- result queue
  result_t            fifo_mem [FIFO_DEPTH];
  result_t            push_res, head;
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;

  assign push_res  = '{last: s3_last_r, col: s3_ccol_r, row: s3_crow_r,
                       sum: total[SUM_W-1:0]};
  assign fifo_push = s3_valid_r;
  assign fifo_pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (fifo_push) fifo_mem[wr_ptr_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (fifo_pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(1);
        2'b01:   fifo_cnt_r <= fifo_cnt_r - FIFO_CW'(1);
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  assign head       = fifo_mem[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tlast  = head.last;
  assign out_tdata  = {(OUT_DATA_W - SUM_W - 2*POS_W)'(0), head.col, head.row, head.sum};

`ifndef SYNTHESIS
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_push && !fifo_pop) |-> (fifo_cnt_r < FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LINE_DEPTH))
    else $error("line store fill count beyond depth");

  a_stage2_origin: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(s1_valid_r && s1_emit_r))
    else $error("window sum started without a completed window");

  a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head.row != '0 && head.col != '0))
    else $error("result centre on the image border");
`endif

endmodule

### tb/ic3k_conv_checker.sv
// Scoreboard for the 3x3 image convolution block: kernel codes, window predictor, comparison.
// Depends on ic3k_pkg for geometry limits, register indexes and the result layout.
// Must be compiled after ic3k_pkg and before image_conv3x3_kernels_tb.
package ic3k_tb_pkg;

  typedef enum logic [2:0] {
    K_LAPLACIAN = 3'd0,
    K_PREWITT_Y = 3'd1,
    K_PREWITT_X = 3'd2,
    K_SOBEL_Y   = 3'd3,
    K_SOBEL_X   = 3'd4,
    K_SHARPEN   = 3'd5,
    K_UNUSED_6  = 3'd6,
    K_UNUSED_7  = 3'd7
  } kernel_code_t;

endpackage

module ic3k_conv_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ic3k_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] pixel
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ic3k_pkg::OUT_DATA_W-1:0]  out_tdata,  // [13:0] sum, [23:14] row,
                                                       // [33:24] column, [39:34] zero
  input  logic                             out_tlast,  // frame_end
  input  logic                             cfg_wr_en,
  input  logic [ic3k_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ic3k_pkg::DIM_W-1:0]       cfg_data,
  output int                               mismatch_count,
  output int                               results_owed,
  output int                               results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import ic3k_pkg::*;
  import ic3k_tb_pkg::*;

  localparam int FIELD_W     = SUM_W + 2 * POS_W;

  logic [PIX_W-1:0] line_mem [2][MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [DIM_W-1:0] cols_reg;
  logic [DIM_W-1:0] rows_reg;
  kernel_code_t     kern_sel;
  result_t          window_sums_q [$];

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_mem[0][i] = '0;
      line_mem[1][i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int l = 0; l < 3; l++)
        win[k][l] = '0;
    col_pos       = 0;
    row_pos       = 0;
    cols_reg      = DIM_RESET;
    rows_reg      = DIM_RESET;
    kern_sel      = kernel_code_t'(KSEL_RESET);
  end

  function automatic int unsigned effective_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v < 3) return 3;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // Weight of window cell (k = line, oldest first; l = column, leftmost first).
  function automatic int kernel_weight(kernel_code_t ks, int k, int l);
    int w;
    case (ks)
      K_LAPLACIAN: w = (k == 1 && l == 1) ? -4 : ((k == 1 || l == 1) ? 1 : 0);
      K_PREWITT_Y: w = k - 1;
      K_PREWITT_X: w = l - 1;
      K_SOBEL_Y:   w = (k - 1) * ((l == 1) ? 2 : 1);
      K_SOBEL_X:   w = (l - 1) * ((k == 1) ? 2 : 1);
      K_SHARPEN:   w = (k == 1 && l == 1) ? 17 : -1;
      default:     w = 0;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatch_count++;
    $display("%0d ns: %s mismatch, got %0d, want %0d", $time, what, got_v, want_v);
  endtask

  task automatic apply_register(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    case (idx)
      REG_IMAGE_COLUMNS: begin
        cols_reg = val;
        col_pos  = 0;
        row_pos  = 0;
      end
      REG_IMAGE_ROWS: begin
        rows_reg = val;
        col_pos  = 0;
        row_pos  = 0;
      end
      REG_KERNEL_SELECT: kern_sel = kernel_code_t'(val[2:0]);
      default: ;
    endcase
  endtask

  // Shift one pixel into the line store and window; queue the sum if the window is full.
  task automatic advance_window(input logic [PIX_W-1:0] px);
    int unsigned      c;
    int unsigned      r;
    int unsigned      cols;
    int unsigned      rows;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    int               acc;
    result_t          res;
    c    = col_pos;
    r    = row_pos;
    cols = effective_dim(cols_reg, MAX_WIDTH);
    rows = effective_dim(rows_reg, MAX_HEIGHT);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    top_px         = line_mem[0][c];
    mid_px         = line_mem[1][c];
    line_mem[0][c] = mid_px;
    line_mem[1][c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = px;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        for (int l = 0; l < 3; l++)
          acc += int'(win[k][l]) * kernel_weight(kern_sel, k, l);
      res.sum  = acc[SUM_W-1:0];
      res.row  = POS_W'(r - 1);
      res.col  = POS_W'(c - 1);
      res.last = (r + 1 == rows) && (c + 1 == cols);
      window_sums_q.push_back(res);
    end
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = {out_tlast, out_tdata[FIELD_W-1:0]};
    results_checked++;
    if (out_tdata[OUT_DATA_W-1:FIELD_W] != '0)
      report_mismatch("tdata padding", int'(out_tdata[OUT_DATA_W-1:FIELD_W]), 0);
    if (window_sums_q.size() == 0) begin
      report_mismatch("unexpected beat, sum", int'($signed(got.sum)), 0);
    end else begin
      want = window_sums_q.pop_front();
      if (got.sum != want.sum)
        report_mismatch("filtered_sum", int'($signed(got.sum)), int'($signed(want.sum)));
      if (got.row != want.row)
        report_mismatch("centre_row", int'(got.row), int'(want.row));
      if (got.col != want.col)
        report_mismatch("centre_column", int'(got.col), int'(want.col));
      if (got.last != want.last)
        report_mismatch("frame_end", int'(got.last), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatch_count  = 0;
      results_checked = 0;
      results_owed   <= 0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_wr_en) apply_register(cfg_reg_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) advance_window(in_tdata[PIX_W-1:0]);
      results_owed <= window_sums_q.size();
    end
  end

endmodule

### tb/image_conv3x3_kernels_tb.sv
// Top-level testbench for image_conv3x3_kernels: clock, reset, pixel and register stimulus.
// Depends on ic3k_pkg and on ic3k_conv_checker (with ic3k_tb_pkg) for prediction and checking.
// Stands alone: no files, no arguments; the simulator seed decides the random content.
module image_conv3x3_kernels_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ic3k_pkg::*;
  import ic3k_tb_pkg::*;

  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 6;
  localparam int RANDOM_PIXELS     = 1200;
  localparam int PRESSURE_SEGMENT  = 4;     // which random segment carries the long stall
  localparam int BACKPRESSURE_HOLD = 400;   // cycles the receiver refuses every beat
  // Quiet-cycle limit: the long stall plus queue drain, taken roughly ten times over.
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int DRAIN_GUARD       = 8;     // covers the pixel-to-result pipeline
  localparam int TAIL_CYCLES       = 16;
  localparam int OVERSIZE_PIXELS   = 90;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en  = 1'b0;
  cfg_reg_t               cfg_index  = REG_IMAGE_COLUMNS;
  logic [DIM_W-1:0]       cfg_data   = '0;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_asked    = 0;
  int stall_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int pixels_sent    = 0;
  int cfg_writes     = 0;
  int mismatch_count;
  int results_owed;
  int results_checked;

  always #CLK_HALF clk = ~clk;

  image_conv3x3_kernels u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ic3k_conv_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  // Result side: drop tready at the current idle rate. A stall request from the
  // stimulus (a bump of stall_asked) starts a long hold counted here, so the
  // result queue fills and the block has to push back on its input.
  always @(posedge clk) begin
    if (stall_asked != stall_served) begin
      stall_served <= stall_asked;
      hold_left    <= BACKPRESSURE_HOLD;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any accepted beat or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, results_owed);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one pixel beat, idling first at the current rate; return on acceptance
  // with tvalid still high so back-to-back beats need no extra edge.
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Close a burst, then hold until every predicted result has been drained and
  // any border pixel still in the pipeline has had time to clear.
  task automatic finish_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Only call while the block is idle. Geometry writes restart the frame;
  // a kernel-only write lets the current frame carry on.
  task automatic program_registers(input logic [DIM_W-1:0] cols,
                                   input logic [DIM_W-1:0] rows,
                                   input kernel_code_t ks, input bit geometry);
    if (geometry) begin
      write_reg(REG_IMAGE_COLUMNS, cols);
      write_reg(REG_IMAGE_ROWS, rows);
    end
    write_reg(REG_KERNEL_SELECT, DIM_W'(ks));
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly uniform grey levels, with a fair share of black and white to hit the sum extremes.
  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(99) < 25) return $urandom_range(1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(255));
  endfunction

  initial begin
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    int               cols_eff;
    int               rows_eff;
    int               burst;
    int               seg;
    int               random_start;
    bit               geometry;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 52;

    // Directed: undersized geometry acts as a 3x3 frame, so each nine-pixel
    // frame gives exactly one result, flagged as the frame end, and the frame wraps.
    // Sharpen with a white centre on black gives the largest sum, the reverse the smallest.
    program_registers(DIM_W'(0), DIM_W'(1), K_SHARPEN, 1'b1);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 8'h00 : 8'hFF);
    finish_burst();
    // An unused kernel code still yields results, all with a zero sum.
    program_registers(DIM_W'(2), DIM_W'(2), K_UNUSED_7, 1'b1);
    for (int i = 0; i < 9; i++) push_pixel(random_pixel());
    finish_burst();

    // Random segments: small frames of random geometry, whole frames plus a
    // partial one, cycling through all eight kernel codes.
    cols_eff     = 3;
    rows_eff     = 3;
    seg          = 0;
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      if (pixels_sent - random_start < RANDOM_PIXELS / 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 52;
      end else if (pixels_sent - random_start < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (seg == PRESSURE_SEGMENT) begin
        // Keep the sender busy while the receiver holds off for a long stretch.
        program_registers(DIM_W'(6), DIM_W'(6), K_SOBEL_Y, 1'b1);
        send_idle_pct = 0;
        stall_asked  <= stall_asked + 1;
        for (int i = 0; i < 150; i++) push_pixel(random_pixel());
      end else begin
        geometry = (seg < 8) || ($urandom_range(3) != 0);
        if ($urandom_range(99) < 10) cols = DIM_W'($urandom_range(2));
        else if ($urandom_range(99) < 85) cols = DIM_W'($urandom_range(3, 10));
        else cols = DIM_W'($urandom_range(11, 24));
        if ($urandom_range(99) < 10) rows = DIM_W'($urandom_range(2));
        else rows = DIM_W'($urandom_range(3, 8));
        program_registers(cols, rows, kernel_code_t'(seg % 8), geometry);
        if (geometry) begin
          cols_eff = (cols < 3) ? 3 : cols;
          rows_eff = (rows < 3) ? 3 : rows;
        end
        burst = $urandom_range(1, 2) * cols_eff * rows_eff + $urandom_range(2 * cols_eff);
        for (int i = 0; i < burst; i++) push_pixel(random_pixel());
      end
      finish_burst();
      seg++;
    end

    // Oversized geometry takes the clamped limits: a short run 1024 wide stays in
    // the first line and gives no result, then a run 1024 high steps through rows.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_registers(DIM_W'(2047), DIM_W'(3), K_PREWITT_X, 1'b1);
    for (int i = 0; i < OVERSIZE_PIXELS; i++) push_pixel(random_pixel());
    finish_burst();
    program_registers(DIM_W'(3), DIM_W'(2047), K_LAPLACIAN, 1'b1);
    for (int i = 0; i < OVERSIZE_PIXELS; i++) push_pixel(random_pixel());
    in_tvalid <= 1'b0;

    // Drain, then give a stray late beat the chance to show up.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels, checked %0d results, made %0d register writes.",
             pixels_sent, results_checked, cfg_writes);
    $display("Run spanned all eight kernel codes, small and oversized geometry and a long stall.");
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
